/* rtl/integer_key_hash_map_unit_defines.svh */
// Assertion macros shared by the hash map unit.
`ifndef INTEGER_KEY_HASH_MAP_UNIT_DEFINES_SVH
`define INTEGER_KEY_HASH_MAP_UNIT_DEFINES_SVH
// An implication checked on every rising edge outside reset.
`define IKHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// An implication whose consequent is checked in the cycle after the antecedent.
`define IKHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/ikhm_pkg.sv */
// ----------------------------------------------------------------------------
// ikhm_pkg
// Types, constants and command structs shared by the hash map unit.
// ----------------------------------------------------------------------------
package ikhm_pkg;
  localparam int MaxBuckets = 64;
  localparam int WaysPerBucket = 4;
  localparam int TableSize = MaxBuckets * WaysPerBucket;
  localparam int BktW = $clog2(MaxBuckets);
  localparam int WayW = (WaysPerBucket > 1) ? $clog2(WaysPerBucket) : 1;
  localparam int AddrW = $clog2(TableSize);
  localparam int CntW = $clog2(WaysPerBucket + 1);
  localparam int DivCntW = 6;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_ADD = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  localparam logic [1:0] OUT_DONE = 2'd0;
  localparam logic [1:0] OUT_ABSENT = 2'd1;
  localparam logic [1:0] OUT_PRESENT = 2'd2;
  localparam logic [1:0] OUT_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [63:0] old_value;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic scan_start;
    logic scan_step;
    logic way_read;
    logic decide;
    logic out_load;
    logic out_take;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_full;
  } sts_t;
endpackage

/* rtl/ikhm_ram.sv */
// ----------------------------------------------------------------------------
// ikhm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ikhm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/ikhm_datapath.sv */
// ----------------------------------------------------------------------------
// ikhm_datapath
// Bucket divider, way scan over the entry memories and result register.
// ----------------------------------------------------------------------------
module ikhm_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  ikhm_pkg::req_t in_req,
  input  logic [6:0]    bucket_count,
  input  ikhm_pkg::cmd_t cmd,
  output ikhm_pkg::sts_t sts,
  output ikhm_pkg::rsp_t out_rsp
);
  import ikhm_pkg::*;
  `include "integer_key_hash_map_unit_defines.svh"

  req_t req_r;
  logic [BktW:0] div_r;
  logic [31:0] quo_r;
  logic [BktW:0] rem_r;
  logic [DivCntW-1:0] dcnt_r;
  logic [BktW-1:0] bkt_r;
  logic [CntW-1:0] way_r;
  logic hit_r, free_r;
  logic [WayW-1:0] hit_way_r, free_way_r;
  logic [TableSize-1:0] valid_r;
  rsp_t out_r;
  logic out_full_r;
  logic [AddrW-1:0] addr;
  logic we_key, we_val;
  logic [31:0] key_rd;
  logic [63:0] val_rd;
  logic [BktW+1:0] trial;
  logic [AddrW-1:0] way_addr;
  logic [AddrW-1:0] hit_addr, free_addr;
  logic [6:0] bc_sat;

  always_comb begin
    bc_sat = bucket_count;
    if (bc_sat == 7'd0) bc_sat = 7'd1;
    if (bc_sat > 7'(MaxBuckets)) bc_sat = 7'(MaxBuckets);
  end

  // Restoring divider, one quotient bit per cycle.
  assign trial = {rem_r, quo_r[31]};
  assign way_addr = {bkt_r, way_r[WayW-1:0]};
  assign hit_addr = {bkt_r, hit_way_r};
  assign free_addr = {bkt_r, free_way_r};

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
    if (cmd.div_start) begin
      div_r <= (BktW+1)'(bc_sat);
      quo_r <= in_req.key;
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, div_r}) begin
        rem_r <= (BktW+1)'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[BktW:0];
      end
      quo_r <= {quo_r[30:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.scan_start) begin
      bkt_r <= rem_r[BktW-1:0];
      way_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (valid_r[way_addr]) begin
        // key compare happens on the following read cycle
      end else if (!free_r) begin
        free_r <= 1'b1;
        free_way_r <= way_r[WayW-1:0];
      end
    end
    if (cmd.way_read && !hit_r && valid_r[way_addr] && key_rd == req_r.key) begin
      hit_r <= 1'b1;
      hit_way_r <= way_r[WayW-1:0];
    end
    if (cmd.way_read) way_r <= way_r + 1'b1;
  end

  assign sts.div_done = (dcnt_r == DivCntW'(32));
  assign sts.scan_done = (way_r == CntW'(WaysPerBucket));
  assign sts.out_full = out_full_r;

  always_comb begin
    addr = way_addr;
    we_key = 1'b0;
    we_val = 1'b0;
    if (cmd.decide) begin
      if (hit_r) begin
        addr = hit_addr;
        we_val = (req_r.kind == KIND_INSERT);
      end else begin
        addr = free_addr;
        we_key = free_r && (req_r.kind == KIND_INSERT || req_r.kind == KIND_ADD);
        we_val = we_key;
      end
    end else if (cmd.scan_start || !cmd.way_read) begin
      addr = hit_r ? hit_addr : way_addr;
    end
  end

  ikhm_ram #(.Width(32), .Depth(TableSize)) u_key_ram (
    .clk(clk), .we(we_key), .addr(addr), .wdata(req_r.key), .rdata(key_rd)
  );
  ikhm_ram #(.Width(64), .Depth(TableSize)) u_val_ram (
    .clk(clk), .we(we_val), .addr(addr), .wdata(req_r.value), .rdata(val_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      out_full_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        if (hit_r && req_r.kind == KIND_DELETE) valid_r[hit_addr] <= 1'b0;
        if (!hit_r && free_r && (req_r.kind == KIND_INSERT || req_r.kind == KIND_ADD))
          valid_r[free_addr] <= 1'b1;
      end
      if (cmd.out_load) out_full_r <= 1'b1;
      else if (cmd.out_take) out_full_r <= 1'b0;
    end
  end

  // At decide the read data holds the hit entry's value.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_r.old_value <= hit_r ? val_rd : 64'd0;
      if (hit_r) begin
        out_r.outcome <= (req_r.kind == KIND_ADD) ? OUT_PRESENT : OUT_DONE;
      end else if (req_r.kind == KIND_LOOKUP || req_r.kind == KIND_DELETE) begin
        out_r.outcome <= OUT_ABSENT;
      end else begin
        out_r.outcome <= free_r ? OUT_DONE : OUT_FULL;
      end
    end
  end
  assign out_rsp = out_r;

  `IKHM_ASSERT_IMP(a_one_cmd, cmd.div_step, !cmd.decide, "divide and decide overlap")
  `IKHM_ASSERT_IMP(a_rem_lt, cmd.scan_start, rem_r < div_r, "remainder out of range")
  `IKHM_ASSERT_NEXT(a_out_set, cmd.out_load, out_full_r, "result not held")
endmodule

/* rtl/ikhm_ctrl.sv */
// ----------------------------------------------------------------------------
// ikhm_ctrl
// Sequencer for divide, way scan, decision and result handoff.
// ----------------------------------------------------------------------------
module ikhm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_stall,
  input  ikhm_pkg::sts_t sts,
  output ikhm_pkg::cmd_t cmd
);
  import ikhm_pkg::*;
  `include "integer_key_hash_map_unit_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic take;

  assign take = sts.out_full && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_take = take;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FETCH;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.way_read = 1'b1;
        state_nxt = S_SCAN;
      end
      S_FETCH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.out_full || take) begin
          cmd.decide = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `IKHM_ASSERT_IMP(a_no_overrun, cmd.out_load, !sts.out_full || take, "result overrun")
  `IKHM_ASSERT_NEXT(a_accept, in_valid && state_r == S_IDLE, state_r == S_DIV, "no divide")
  `IKHM_ASSERT_IMP(a_busy, state_r != S_IDLE, in_stall, "accept while busy")
endmodule

/* rtl/integer_key_hash_map_unit.sv */
// ----------------------------------------------------------------------------
// integer_key_hash_map_unit
// Hash table of 32-bit keys to 64-bit values with fixed ways per bucket.
// ----------------------------------------------------------------------------
// The request channel (in_valid, in_stall, in_data) carries one request beat:
// kind, key and value. The result channel (out_valid, out_stall, out_data)
// returns one beat per request: outcome and old value.
// cfg_we with cfg_data writes the bucket count; write it only while idle.
// An accepted request passes through the bit-serial divider that reduces the
// key to a bucket, then the bucket scan over the entry memories, which reads
// each way of the bucket in turn, and then the steps that end the scan, fetch
// the hit value and update the table before its result is valid.
// One request is in flight at a time: in_stall stays high until it loads its result.
// The result register holds a beat while out_stall is high; the
// next request is accepted and processed meanwhile and waits to deliver.
// Reset clears all valid bits at once and sets the bucket count to 64.
module integer_key_hash_map_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ikhm_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ikhm_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_data
);
  import ikhm_pkg::*;

  logic [6:0] bucket_count_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= 7'd64;
    else if (cfg_we) bucket_count_r <= cfg_data;
  end

  ikhm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ikhm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_data), .bucket_count(bucket_count_r),
    .cmd(cmd), .sts(sts), .out_rsp(out_data)
  );

  assign out_valid = sts.out_full;
endmodule
